// ===== sv/assert_macros.svh =====
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ===== sv/tls_pkg.sv =====
package tls_pkg;
	localparam logic [5:0] KIND_ID     = 6'd0;
	localparam logic [5:0] KIND_STMT   = 6'd10;
	localparam logic [5:0] KIND_NUMBER = 6'd11;
	localparam logic [5:0] KIND_STRING = 6'd12;
	localparam logic [5:0] KIND_EOF    = 6'd49;
	localparam logic [5:0] KIND_NONE   = 6'd63;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_CHAR  = 2'd1;
	localparam logic [1:0] ST_STR   = 2'd2;
	localparam logic [1:0] ST_LONG  = 2'd3;

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_WORD   = 3'd1;
	localparam logic [2:0] MODE_NUMBER = 3'd2;
	localparam logic [2:0] MODE_STRING = 3'd3;
	localparam logic [2:0] MODE_OPER   = 3'd4;
	localparam logic [2:0] MODE_WAIT   = 3'd5;

	typedef struct packed {
		logic [5:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic [1:0]  status;
		logic        last;
	} tok_t;

	typedef struct packed {
		logic [1:0] count;
		tok_t       t0;
		tok_t       t1;
		tok_t       t2;
	} bundle_t;

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return b == 8'd13 || b == 8'd10 || b == 8'h20 || b == 8'h09;
	endfunction

	function automatic logic [5:0] single_kind(input logic [7:0] c);
		unique case (c)
			"(": return 6'd13; ")": return 6'd14; "{": return 6'd15;
			"}": return 6'd16; "[": return 6'd17; "]": return 6'd18;
			"=": return 6'd19; ":": return 6'd21; ";": return 6'd22;
			".": return 6'd23; ",": return 6'd24; ">": return 6'd25;
			"<": return 6'd28; "+": return 6'd31; "-": return 6'd33;
			"*": return 6'd35; "%": return 6'd37; "/": return 6'd39;
			"!": return 6'd41; "&": return 6'd43; "|": return 6'd46;
			default: return KIND_NONE;
		endcase
	endfunction

	function automatic logic needs_lookahead(input logic [7:0] c);
		return c == "=" || c == ">" || c == "<" || c == "+" || c == "-" || c == "*" ||
			c == "%" || c == "/" || c == "!" || c == "&" || c == "|";
	endfunction

	function automatic logic [5:0] pair_kind(input logic [7:0] a, input logic [7:0] b);
		if (b == "=") begin
			unique case (a)
				"=": return 6'd20; ">": return 6'd26; "<": return 6'd29;
				"+": return 6'd32; "-": return 6'd34; "*": return 6'd36;
				"%": return 6'd38; "/": return 6'd40; "!": return 6'd42;
				"&": return 6'd44; "|": return 6'd47;
				default: return KIND_NONE;
			endcase
		end
		if (a == ">" && b == ">") return 6'd27;
		if (a == "<" && b == "<") return 6'd30;
		if (a == "<" && b == "-") return KIND_STMT;
		if (a == "&" && b == "&") return 6'd45;
		if (a == "|" && b == "|") return 6'd48;
		return KIND_NONE;
	endfunction

	function automatic logic [5:0] word_kind(input logic [39:0] p, input logic [2:0] n);
		unique case (n)
			3'd2: begin
				if (p[15:0] == "fn") return 6'd5;
				if (p[15:0] == "if") return KIND_STMT;
				return KIND_ID;
			end
			3'd3: begin
				if (p[23:0] == "let") return 6'd3;
				if (p[23:0] == "int") return 6'd4;
				if (p[23:0] == "vec") return 6'd6;
				if (p[23:0] == "str") return 6'd7;
				if (p[23:0] == "for") return KIND_STMT;
				return KIND_ID;
			end
			3'd4: begin
				if (p[31:0] == "true") return 6'd1;
				if (p[31:0] == "bool") return 6'd9;
				if (p[31:0] == "loop" || p[31:0] == "else" || p[31:0] == "elif" ||
					p[31:0] == "exit") return KIND_STMT;
				return KIND_ID;
			end
			3'd5: begin
				if (p == "false") return 6'd2;
				if (p == "float") return 6'd8;
				if (p == "while") return KIND_STMT;
				return KIND_ID;
			end
			default: return KIND_ID;
		endcase
	endfunction
endpackage

// ===== sv/tls_stream_if.sv =====
interface tls_stream_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/tls_front.sv =====
// scanner: one byte per transaction, yields a bundle of up to three tokens
module tls_front #(
	parameter int PW = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           source_byte,
	input  logic                 end_of_source,
	output logic                 push,
	input  logic                 full,
	output tls_pkg::bundle_t     bundle
);
	import tls_pkg::*;

	logic [2:0]    mode_q;
	logic [7:0]    pend_q;
	logic [PW-1:0] pos_q;
	logic [PW-1:0] tstart_q;
	logic [39:0]   prefix_q;
	logic [2:0]    wlen_q;

	logic [2:0]    mode_d;
	logic [7:0]    pend_d;
	logic [PW-1:0] pos_d;
	logic [PW-1:0] tstart_d;
	logic [39:0]   prefix_d;
	logic [2:0]    wlen_d;
	tok_t          t [3];
	logic [1:0]    n;
	logic          fire;

	assign in_ready = !full;
	assign fire = in_valid && in_ready;

	function automatic tok_t mk(input logic [5:0] k, input logic [PW-1:0] s,
		input logic [PW-1:0] l, input logic [1:0] st);
		tok_t r;
		r.kind = k;
		r.start = 16'(s);
		r.length = (PW > 16 && (l >> 16) != '0) ? 16'hffff : 16'(l);
		r.status = st;
		r.last = 1'b0;
		return r;
	endfunction

	always_comb begin
		logic [7:0] b;
		logic [PW-1:0] p1;
		logic redo;
		b = source_byte;
		mode_d = mode_q; pend_d = pend_q; pos_d = pos_q; tstart_d = tstart_q;
		prefix_d = prefix_q; wlen_d = wlen_q;
		n = 2'd0;
		t[0] = '0; t[1] = '0; t[2] = '0;
		redo = 1'b0;
		p1 = pos_q + 1'b1;
		if (mode_q == MODE_WAIT) begin
			if (b == 8'd0 || end_of_source) begin
				mode_d = MODE_IDLE; pend_d = '0; pos_d = '0; tstart_d = '0;
				prefix_d = '0; wlen_d = '0;
			end
		end else begin
			if (b != 8'd0) begin
				if (pos_q == '1) begin
					t[n] = mk(KIND_EOF, pos_q, '0, ST_LONG); n = n + 1'b1;
					mode_d = MODE_WAIT;
				end else begin
					redo = 1'b1;
					unique case (mode_q)
						MODE_WORD: begin
							if (is_alpha(b) || is_digit(b)) begin
								redo = 1'b0;
								if (wlen_q < 3'd5) begin
									prefix_d = {prefix_q[31:0], b};
									wlen_d = wlen_q + 1'b1;
								end else wlen_d = 3'd6;
							end else begin
								t[n] = mk(word_kind(prefix_q, wlen_q), tstart_q,
									pos_q - tstart_q, ST_OK);
								n = n + 1'b1;
							end
						end
						MODE_NUMBER: begin
							if (is_digit(b) || b == ".") redo = 1'b0;
							else begin
								t[n] = mk(KIND_NUMBER, tstart_q, pos_q - tstart_q, ST_OK);
								n = n + 1'b1;
							end
						end
						MODE_STRING: begin
							redo = 1'b0;
							if (b == "\"") begin
								t[n] = mk(KIND_STRING, tstart_q, pos_q - tstart_q, ST_OK);
								n = n + 1'b1;
								mode_d = MODE_IDLE;
							end
						end
						MODE_OPER: begin
							if (pair_kind(pend_q, b) != KIND_NONE) begin
								t[n] = mk(pair_kind(pend_q, b), tstart_q, PW'(2), ST_OK);
								n = n + 1'b1;
								mode_d = MODE_IDLE;
								redo = 1'b0;
							end else begin
								t[n] = mk(single_kind(pend_q), tstart_q, PW'(1), ST_OK);
								n = n + 1'b1;
							end
						end
						default: ;
					endcase
					if (redo) begin
						mode_d = MODE_IDLE;
						if (is_blank(b)) ;
						else if (is_alpha(b)) begin
							mode_d = MODE_WORD; tstart_d = pos_q;
							prefix_d = {32'd0, b}; wlen_d = 3'd1;
						end else if (is_digit(b)) begin
							mode_d = MODE_NUMBER; tstart_d = pos_q;
						end else if (b == "\"") begin
							mode_d = MODE_STRING; tstart_d = p1;
						end else if (needs_lookahead(b)) begin
							mode_d = MODE_OPER; pend_d = b; tstart_d = pos_q;
						end else if (single_kind(b) != KIND_NONE) begin
							t[n] = mk(single_kind(b), pos_q, PW'(1), ST_OK);
							n = n + 1'b1;
						end else begin
							t[n] = mk(KIND_EOF, pos_q, '0, ST_CHAR);
							n = n + 1'b1;
							mode_d = MODE_WAIT;
						end
					end
					pos_d = p1;
				end
			end
			if (b == 8'd0 || end_of_source) begin
				if (mode_d != MODE_WAIT) begin
					unique case (mode_d)
						MODE_WORD: begin
							t[n] = mk(word_kind(prefix_d, wlen_d), tstart_d,
								pos_d - tstart_d, ST_OK);
							n = n + 1'b1;
						end
						MODE_NUMBER: begin
							t[n] = mk(KIND_NUMBER, tstart_d, pos_d - tstart_d, ST_OK);
							n = n + 1'b1;
						end
						MODE_OPER: begin
							t[n] = mk(single_kind(pend_d), tstart_d, PW'(1), ST_OK);
							n = n + 1'b1;
						end
						default: ;
					endcase
					t[n] = mk(KIND_EOF, pos_d, '0,
						(mode_d == MODE_STRING) ? ST_STR : ST_OK);
					n = n + 1'b1;
				end
				mode_d = MODE_IDLE; pend_d = '0; pos_d = '0; tstart_d = '0;
				prefix_d = '0; wlen_d = '0;
			end
		end
	end

	assign push = fire && n != 2'd0;
	assign bundle = '{count: n, t0: t[0], t1: t[1], t2: t[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE; pend_q <= '0; pos_q <= '0; tstart_q <= '0;
			prefix_q <= '0; wlen_q <= '0;
		end else if (fire) begin
			mode_q <= mode_d; pend_q <= pend_d; pos_q <= pos_d; tstart_q <= tstart_d;
			prefix_q <= prefix_d; wlen_q <= wlen_d;
		end
	end
endmodule

// ===== sv/tls_back.sv =====
// two-entry bundle queue and token serializer
module tls_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  tls_pkg::bundle_t bundle,
	output logic             out_valid,
	input  logic             out_ready,
	output tls_pkg::tok_t    token
);
	import tls_pkg::*;

	bundle_t    mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic [1:0] idx_q;
	bundle_t    head;
	logic       pop, take;

	assign full = cnt_q == 2'd2;
	assign head = mem_q[rp_q];
	assign out_valid = cnt_q != 2'd0;
	assign take = out_valid && out_ready;
	assign pop = take && (idx_q + 1'b1 == head.count);

	always_comb begin
		unique case (idx_q)
			2'd0: token = head.t0;
			2'd1: token = head.t1;
			default: token = head.t2;
		endcase
		token.last = idx_q + 1'b1 == head.count;
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= bundle;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0; idx_q <= '0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
			if (pop) idx_q <= '0;
			else if (take) idx_q <= idx_q + 1'b1;
		end
	end
endmodule

// ===== sv/token_lexer_stream_top.sv =====
// channel  dir  payload
// src      in   source_byte, end_of_source
// tok      out  token_kind, token_start, token_length, lex_status, last_of_run
// one source byte per cycle; the scanner updates its state in the cycle a byte
// is accepted and pushes that byte's tokens (up to three) into a two-entry queue.
// the serializer drains one token per cycle while tok is ready.
// reset clears scanner state and queue pointers; src stalls only when queue is full.
`include "assert_macros.svh"
module token_lexer_stream_top #(
	parameter int POSITION_WIDTH = 16
) (
	input logic     clk,
	input logic     arst_n,
	tls_stream_if.sink   src,
	tls_stream_if.source tok
);
	import tls_pkg::*;

	logic    push, full;
	bundle_t bundle;
	tok_t    token;

	tls_front #(.PW(POSITION_WIDTH)) u_front (
		.clk, .arst_n,
		.in_valid(src.valid), .in_ready(src.ready),
		.source_byte(src.payload[8:1]), .end_of_source(src.payload[0]),
		.push, .full, .bundle
	);

	tls_back u_back (
		.clk, .arst_n, .push, .full, .bundle,
		.out_valid(tok.valid), .out_ready(tok.ready), .token
	);

	assign tok.payload = token;

	`ASSERT_IMPLIES(a_no_push_full, clk, arst_n, full, !push)
	`ASSERT_IMPLIES(a_cnt_nonzero, clk, arst_n, push, bundle.count != 2'd0)
	`ASSERT_IMPLIES(a_err_len, clk, arst_n, tok.valid && token.status != ST_OK,
		token.kind == KIND_EOF && token.length == 16'd0)
endmodule

// ===== tb/token_lexer_stream_top_test.sv =====
module token_lexer_stream_top_test;
	import tls_pkg::*;

	typedef enum logic [5:0] {
		K_TRUE = 6'd1, K_FALSE, K_LET, K_INT, K_FN, K_VEC, K_STR, K_FLOAT, K_BOOL,
		K_LPAREN = 6'd13, K_RPAREN, K_LBRACE, K_RBRACE, K_LBRACK, K_RBRACK,
		K_ASSIGN, K_EQ, K_COLON, K_SEMI, K_DOT, K_COMMA, K_GT, K_GE, K_SHR,
		K_LT, K_LE, K_SHL, K_PLUS, K_PLUSEQ, K_MINUS, K_MINUSEQ, K_STAR, K_STAREQ,
		K_PCT, K_PCTEQ, K_SLASH, K_SLASHEQ, K_BANG, K_NE, K_AMP, K_AMPEQ,
		K_ANDAND, K_BAR, K_BAREQ, K_OROR
	} tok_kind_e;

	localparam int POS_LIMIT = 65535;
	localparam bit END_ZERO = 1'b0;
	localparam bit END_FLAG = 1'b1;

	logic clk;
	logic arst_n;

	tls_stream_if #(9) src_if ();
	tls_stream_if #(41) tok_if ();

	token_lexer_stream_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.src(src_if),
		.tok(tok_if)
	);

	// lexer state mirror
	logic [2:0] lx_mode;
	logic [7:0] lx_pend;
	int lx_pos;
	int lx_tstart;
	logic [39:0] lx_prefix;
	int lx_wlen;

	tok_t token_fifo[$];
	int errors;
	int hold_cycles;
	int stall_left;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	task automatic report(input string what, input logic [40:0] got, input logic [40:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h", what, got, want);
	endtask

	function automatic bit is_letter(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic bit is_num(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic [5:0] op_kind(input logic [7:0] c);
		case (c)
			"(": return K_LPAREN;  ")": return K_RPAREN;  "{": return K_LBRACE;
			"}": return K_RBRACE;  "[": return K_LBRACK;  "]": return K_RBRACK;
			"=": return K_ASSIGN;  ":": return K_COLON;   ";": return K_SEMI;
			".": return K_DOT;     ",": return K_COMMA;   ">": return K_GT;
			"<": return K_LT;      "+": return K_PLUS;    "-": return K_MINUS;
			"*": return K_STAR;    "%": return K_PCT;     "/": return K_SLASH;
			"!": return K_BANG;    "&": return K_AMP;     "|": return K_BAR;
			default: return KIND_NONE;
		endcase
	endfunction

	function automatic bit wants_next(input logic [7:0] c);
		return c inside {"=", ">", "<", "+", "-", "*", "%", "/", "!", "&", "|"};
	endfunction

	function automatic logic [5:0] two_char_kind(input logic [7:0] a, input logic [7:0] b);
		// every "x=" form directly follows its one-character kind
		if (b == "=") return op_kind(a) + 6'd1;
		if (a == ">" && b == ">") return K_SHR;
		if (a == "<" && b == "<") return K_SHL;
		if (a == "<" && b == "-") return KIND_STMT;
		if (a == "&" && b == "&") return K_ANDAND;
		if (a == "|" && b == "|") return K_OROR;
		return KIND_NONE;
	endfunction

	function automatic logic [5:0] keyword_kind();
		if (lx_wlen > 5) return KIND_ID;
		case ({lx_wlen[2:0], lx_prefix})
			{3'd4, 8'h0, "true"}: return K_TRUE;
			{3'd5, "false"}: return K_FALSE;
			{3'd3, 16'h0, "let"}: return K_LET;
			{3'd3, 16'h0, "int"}: return K_INT;
			{3'd2, 24'h0, "fn"}: return K_FN;
			{3'd3, 16'h0, "vec"}: return K_VEC;
			{3'd3, 16'h0, "str"}: return K_STR;
			{3'd5, "float"}: return K_FLOAT;
			{3'd4, 8'h0, "bool"}: return K_BOOL;
			{3'd2, 24'h0, "if"}, {3'd3, 16'h0, "for"}, {3'd5, "while"},
			{3'd4, 8'h0, "loop"}, {3'd4, 8'h0, "else"}, {3'd4, 8'h0, "elif"},
			{3'd4, 8'h0, "exit"}: return KIND_STMT;
			default: return KIND_ID;
		endcase
	endfunction

	function automatic void push_token(input logic [5:0] k, input int at, input int len,
			input logic [1:0] st);
		tok_t t;
		t.kind = k;
		t.start = at[15:0];
		t.length = (len > 65535) ? 16'hFFFF : len[15:0];
		t.status = st;
		t.last = 1'b0;
		token_fifo.push_back(t);
	endfunction

	function automatic void clear_lexer();
		lx_mode = MODE_IDLE;
		lx_pend = 8'h0;
		lx_pos = 0;
		lx_tstart = 0;
		lx_prefix = 40'h0;
		lx_wlen = 0;
	endfunction

	function automatic void lex_error(input int at, input logic [1:0] st);
		push_token(KIND_EOF, at, 0, st);
		lx_mode = MODE_WAIT;
	endfunction

	function automatic void begin_token(input logic [7:0] b, input int at);
		lx_mode = MODE_IDLE;
		if (b == 8'd13 || b == 8'd10 || b == " " || b == 8'd9) return;
		if (is_letter(b)) begin
			lx_mode = MODE_WORD;
			lx_tstart = at;
			lx_prefix = {32'h0, b};
			lx_wlen = 1;
		end else if (is_num(b)) begin
			lx_mode = MODE_NUMBER;
			lx_tstart = at;
		end else if (b == "\"") begin
			lx_mode = MODE_STRING;
			lx_tstart = at + 1;
		end else if (wants_next(b)) begin
			lx_mode = MODE_OPER;
			lx_pend = b;
			lx_tstart = at;
		end else if (op_kind(b) != KIND_NONE) begin
			push_token(op_kind(b), at, 1, ST_OK);
		end else begin
			lex_error(at, ST_CHAR);
		end
	endfunction

	function automatic void scan_char(input logic [7:0] b, input int at);
		logic [5:0] k;
		case (lx_mode)
			MODE_WORD: begin
				if (is_letter(b) || is_num(b)) begin
					if (lx_wlen < 5) begin
						lx_prefix = {lx_prefix[31:0], b};
						lx_wlen++;
					end else begin
						lx_wlen = 6;
					end
					return;
				end
				push_token(keyword_kind(), lx_tstart, at - lx_tstart, ST_OK);
			end
			MODE_NUMBER: begin
				if (is_num(b) || b == ".") return;
				push_token(KIND_NUMBER, lx_tstart, at - lx_tstart, ST_OK);
			end
			MODE_STRING: begin
				if (b == "\"") begin
					push_token(KIND_STRING, lx_tstart, at - lx_tstart, ST_OK);
					lx_mode = MODE_IDLE;
				end
				return;
			end
			MODE_OPER: begin
				k = two_char_kind(lx_pend, b);
				if (k != KIND_NONE) begin
					push_token(k, lx_tstart, 2, ST_OK);
					lx_mode = MODE_IDLE;
					return;
				end
				push_token(op_kind(lx_pend), lx_tstart, 1, ST_OK);
			end
			default: ;
		endcase
		begin_token(b, at);
	endfunction

	function automatic void close_source(input int at);
		case (lx_mode)
			MODE_WORD: push_token(keyword_kind(), lx_tstart, at - lx_tstart, ST_OK);
			MODE_NUMBER: push_token(KIND_NUMBER, lx_tstart, at - lx_tstart, ST_OK);
			MODE_OPER: push_token(op_kind(lx_pend), lx_tstart, 1, ST_OK);
			MODE_STRING: begin
				push_token(KIND_EOF, at, 0, ST_STR);
				return;
			end
			default: ;
		endcase
		push_token(KIND_EOF, at, 0, ST_OK);
	endfunction

	function automatic void lex_byte(input logic [7:0] b, input bit e);
		int n0;
		n0 = token_fifo.size();
		if (lx_mode == MODE_WAIT) begin
			if (b == 8'h0 || e) clear_lexer();
			return;
		end
		if (b == 8'h0) begin
			close_source(lx_pos);
			clear_lexer();
		end else begin
			if (lx_pos >= POS_LIMIT) begin
				lex_error(lx_pos, ST_LONG);
			end else begin
				scan_char(b, lx_pos);
				lx_pos++;
			end
			if (e) begin
				if (lx_mode != MODE_WAIT) close_source(lx_pos);
				clear_lexer();
			end
		end
		if (token_fifo.size() > n0) token_fifo[token_fifo.size() - 1].last = 1'b1;
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit e);
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < 20)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 3);
		if (gap > 0) begin
			src_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_if.valid <= 1'b1;
		src_if.payload <= {b, e};
		@(posedge clk);
		while (!src_if.ready) @(posedge clk);
		lex_byte(b, e);
	endtask

	// the last byte carries the end flag, or a zero byte follows
	task automatic send_source(input byte unsigned text[$], input bit how);
		foreach (text[i])
			send_byte(text[i], how == END_FLAG && i == text.size() - 1);
		if (how == END_ZERO) send_byte(8'h0, $urandom_range(0, 1));
	endtask

	task automatic add_text(inout byte unsigned text[$], input string s);
		for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
	endtask

	task automatic add_random_token(inout byte unsigned text[$]);
		string kw[16];
		string ops;
		int sel;
		int n;
		kw = '{"true", "false", "let", "int", "fn", "vec", "str", "float", "bool",
			"if", "for", "while", "loop", "else", "elif", "exit"};
		ops = "(){}[]=:;.,><+-*%/!&|";
		sel = $urandom_range(0, 9);
		case (sel)
			0, 1: add_text(text, kw[$urandom_range(0, 15)]);
			2: begin
				n = $urandom_range(1, 8);
				text.push_back(8'(8'("a") + $urandom_range(0, 25)));
				for (int i = 1; i < n; i++)
					text.push_back($urandom_range(0, 1) ? 8'(8'("0") + $urandom_range(0, 9))
						: 8'(8'("A") + $urandom_range(0, 25)));
			end
			3: begin
				n = $urandom_range(1, 5);
				for (int i = 0; i < n; i++)
					text.push_back($urandom_range(0, 3) ? 8'(8'("0") + $urandom_range(0, 9))
						: 8'("."));
			end
			4: begin
				text.push_back("\"");
				n = $urandom_range(0, 4);
				for (int i = 0; i < n; i++) text.push_back($urandom_range(1, 255) == 34 ? 8'h41
					: 8'($urandom_range(1, 255)));
				text.push_back("\"");
			end
			5, 6, 7: begin
				text.push_back(ops[$urandom_range(0, ops.len() - 1)]);
				if ($urandom_range(0, 1)) text.push_back(ops[$urandom_range(0, ops.len() - 1)]);
			end
			8: text.push_back(8'($urandom_range(1, 255)));
			default: ;
		endcase
		case ($urandom_range(0, 5))
			0: text.push_back(" ");
			1: text.push_back(8'd9);
			2: text.push_back(8'd10);
			3: text.push_back(8'd13);
			default: ;
		endcase
	endtask

	task automatic random_source(input int ntok);
		byte unsigned text[$];
		for (int i = 0; i < ntok; i++) add_random_token(text);
		if (text.size() == 0) text.push_back("x");
		send_source(text, $urandom_range(0, 1) ? END_FLAG : END_ZERO);
	endtask

	task automatic wait_drained();
		src_if.valid <= 1'b0;
		wait (token_fifo.size() == 0);
		repeat (6) @(posedge clk);
	endtask

	task automatic test_directed();
		byte unsigned text[$];
		add_text(text, "x<-1.5 \"hi\"");
		send_source(text, END_ZERO);
		text = {};
		add_text(text, "a&&b||c>=");
		send_source(text, END_FLAG);
		text = {};
		// unexpected character, then ignored bytes until end of source
		add_text(text, "ab@q\"");
		text.push_back(8'hFF);
		send_source(text, END_FLAG);
		text = {};
		add_text(text, "\"ab");
		send_source(text, END_FLAG);
		text = {};
		add_text(text, "whilex >");
		send_source(text, END_ZERO);
		send_byte(8'h0, 1'b0);
		wait_drained();
	endtask

	task automatic test_random();
		for (int i = 0; i < 5; i++) random_source($urandom_range(1, 3));
		wait_drained();
	endtask

	task automatic test_backpressure();
		byte unsigned text[$];
		hold_cycles = 60;
		// operators that do not pair give a token on nearly every byte
		add_text(text, "+-*/%!<>=|&+-*/");
		send_source(text, END_FLAG);
		wait_drained();
		for (int i = 0; i < 2; i++) begin
			random_source($urandom_range(2, 3));
			wait_drained();
		end
	endtask

	// receiver side: random stalls plus a long hold on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_if.ready <= 1'b0;
			stall_left <= 0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			tok_if.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			tok_if.ready <= 1'b0;
		end else if ($urandom_range(0, 99) < 10) begin
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
			tok_if.ready <= 1'b0;
		end else begin
			tok_if.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		tok_t got;
		tok_t want;
		if (arst_n && tok_if.valid && tok_if.ready) begin
			got = tok_if.payload;
			if (token_fifo.size() == 0) begin
				report("unexpected transaction", got, '0);
			end else begin
				want = token_fifo.pop_front();
				if (got.kind != want.kind) report("token_kind", got.kind, want.kind);
				if (got.start != want.start) report("token_start", got.start, want.start);
				if (got.length != want.length) report("token_length", got.length, want.length);
				if (got.status != want.status) report("lex_status", got.status, want.status);
				if (got.last != want.last) report("last_of_run", got.last, want.last);
			end
		end
	end

	initial begin
		#8_000_000;
		$display("token_lexer_stream_top regression: fail");
		$finish;
	end

	initial begin
		errors = 0;
		hold_cycles = 0;
		arst_n = 1'b0;
		src_if.valid = 1'b0;
		src_if.payload = '0;
		clear_lexer();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		wait_drained();
		repeat (20) @(posedge clk);
		if (errors == 0 && token_fifo.size() == 0)
			$display("token_lexer_stream_top regression: pass");
		else
			$display("token_lexer_stream_top regression: fail");
		$finish;
	end
endmodule
